[hdl/poly_pkg.sv]
// Shared types and constants for the polynomial evaluator.
// Used by poly_step and polynomial_evaluator; no dependencies.
`default_nettype none

package poly_pkg;

   localparam int DATA_W         = 32;
   localparam int FRAC_W         = 16;
   localparam int PROD_W         = 2 * DATA_W;
   localparam int SUM_W          = PROD_W - FRAC_W + 1;
   localparam int NUM_COEF       = 7;
   localparam int MAX_DEGREE_DEF = 6;
   localparam int ADDR_W         = 5;
   localparam int REG_IDX_W      = ADDR_W - 2;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
   localparam logic [DATA_W-1:0] Q_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] Q_MIN      = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] acc;
      logic signed [DATA_W-1:0] x;
      logic                     sat;
   } step_word_type;

endpackage

`default_nettype wire

[hdl/poly_step.sv]
// One Horner step: registered 32x32 multiply, then round, shift, add coefficient
// and saturate into a second register. Depends on poly_pkg.
`default_nettype none

module poly_step
   import poly_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     enable,
   input  wire logic signed [DATA_W-1:0] coef,
   input  wire logic                     in_valid,
   input  wire step_word_type            in_word,
   output logic                          out_valid,
   output step_word_type                 out_word
);

   logic                     mul_valid_ff, mul_valid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] mul_x_ff;
   logic                     mul_sat_ff;

   logic signed [PROD_W-1:0]        rounded;
   logic signed [PROD_W-FRAC_W-1:0] scaled;
   logic signed [SUM_W-1:0]         total;
   logic                            ovf;

   logic          res_valid_ff, res_valid_in;
   step_word_type res_ff, res_in;

   always_comb begin
      prod_in      = $signed(in_word.acc) * $signed(in_word.x);
      mul_valid_in = enable ? in_valid : mul_valid_ff;

      rounded = prod_ff + $signed(ROUND_HALF);
      scaled  = $signed(rounded[PROD_W-1:FRAC_W]);
      total   = SUM_W'(scaled) + SUM_W'(coef);
      ovf     = total[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){total[SUM_W-1]}};

      res_in.x   = mul_x_ff;
      res_in.sat = mul_sat_ff | ovf;
      if (ovf) begin
         res_in.acc = total[SUM_W-1] ? $signed(Q_MIN) : $signed(Q_MAX);
      end else begin
         res_in.acc = $signed(total[DATA_W-1:0]);
      end
      res_valid_in = enable ? mul_valid_ff : res_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff    <= prod_in;
         mul_x_ff   <= in_word.x;
         mul_sat_ff <= in_word.sat;
         res_ff     <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_word  = res_ff;

endmodule

`default_nettype wire

[hdl/polynomial_evaluator.sv]
// Top level of the Horner polynomial evaluator: coefficient registers, input
// stage and a chain of poly_step instances. Depends on poly_pkg and poly_step.
`default_nettype none

// Evaluates y = sum of coef_i * x^i (signed Q16.16) by Horner's rule, one
// argument word per cycle unless stalled. The pipeline is an input register
// and, per degree, a multiply stage and a round/add/saturate stage. The whole
// pipeline holds only while a result sits on the output and is stalled.
// rsp_saturated is set when any step clipped. Coefficients live at byte
// address 4*i; write them only while no words are in flight.
module polynomial_evaluator
   import poly_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [DATA_W-1:0] req_arg_x,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DATA_W-1:0]      rsp_result_y,
   output logic                   rsp_saturated,

   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic signed [DATA_W-1:0] coef_ff [NUM_COEF];
   logic [REG_IDX_W-1:0]     reg_idx;
   logic                     csr_wr;

   logic          advance;
   logic          in_valid_ff, in_valid_in;
   step_word_type in_word_ff, in_word_in;

   logic          chain_valid [MAX_DEGREE+1];
   step_word_type chain_word  [MAX_DEGREE+1];

   // register file
   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (32'(reg_idx) < NUM_COEF) ? coef_ff[reg_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_wr && (32'(reg_idx) < NUM_COEF)) begin
         coef_ff[reg_idx] <= $signed(csr_pwdata);
      end
   end

   // input stage
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      in_valid_in    = advance ? req_valid : in_valid_ff;
      in_word_in.acc = coef_ff[MAX_DEGREE];
      in_word_in.x   = $signed(req_arg_x);
      in_word_in.sat = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_word_ff <= in_word_in;
      end
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_word[0]  = in_word_ff;

   for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
      poly_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .coef      (coef_ff[MAX_DEGREE-1-k]),
         .in_valid  (chain_valid[k]),
         .in_word   (chain_word[k]),
         .out_valid (chain_valid[k+1]),
         .out_word  (chain_word[k+1])
      );
   end

   assign rsp_valid     = chain_valid[MAX_DEGREE];
   assign rsp_result_y  = chain_word[MAX_DEGREE].acc;
   assign rsp_saturated = chain_word[MAX_DEGREE].sat;

   a_stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted word missing from input stage");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (in_valid_ff == $past(in_valid_ff)) && $stable(in_word_ff))
      else $error("input stage moved during stall");

   a_coef_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && (reg_idx == '0)) |=> (coef_ff[0] == $signed($past(csr_pwdata))))
      else $error("coefficient write lost");

endmodule

`default_nettype wire

[tb/poly_checker.sv]
// Checker for the polynomial evaluator: snoops coefficient writes, predicts
// each result word by Horner's rule and compares it with the rsp channel.
// Depends on poly_pkg.
`timescale 1ns / 1ps

module poly_checker
   import poly_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [DATA_W-1:0] req_arg_x,

   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [DATA_W-1:0] rsp_result_y,
   input  wire logic              rsp_saturated,

   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic              csr_pready,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,

   output int                     error_count,
   output int                     pending_count
);

   typedef struct packed {
      logic [DATA_W-1:0] result_y;
      logic              saturated;
   } poly_value_type;

   logic signed [DATA_W-1:0] coef_copy [NUM_COEF];
   poly_value_type           expected_values [$];
   logic [REG_IDX_W-1:0]     reg_index;

   assign reg_index = csr_paddr[ADDR_W-1:2];

   function automatic poly_value_type horner_eval(input logic signed [DATA_W-1:0] arg);
      longint         acc;
      longint         scaled;
      poly_value_type value;
      value.saturated = 1'b0;
      acc = coef_copy[MAX_DEGREE];
      for (int i = MAX_DEGREE - 1; i >= 0; i--) begin
         // exact product, round half up, floor shift
         scaled = (acc * longint'(arg) + 64'sd32768) >>> FRAC_W;
         acc = scaled + longint'(coef_copy[i]);
         if (acc > longint'($signed(Q_MAX))) begin
            acc = longint'($signed(Q_MAX));
            value.saturated = 1'b1;
         end else if (acc < longint'($signed(Q_MIN))) begin
            acc = longint'($signed(Q_MIN));
            value.saturated = 1'b1;
         end
      end
      value.result_y = DATA_W'(acc);
      return value;
   endfunction

   always @(posedge clock) begin
      poly_value_type expv;
      if (reset) begin
         foreach (coef_copy[i]) coef_copy[i] <= '0;
         expected_values.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_index < NUM_COEF)
            coef_copy[reg_index] <= csr_pwdata;
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               $error("result word with no pending expectation: result_y %h saturated %b",
                      rsp_result_y, rsp_saturated);
               error_count++;
            end else begin
               expv = expected_values.pop_front();
               if (rsp_result_y !== expv.result_y) begin
                  $error("result_y mismatch: expected %h, actual %h",
                         expv.result_y, rsp_result_y);
                  error_count++;
               end
               if (rsp_saturated !== expv.saturated) begin
                  $error("saturated mismatch: expected %b, actual %b",
                         expv.saturated, rsp_saturated);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_values.push_back(horner_eval(req_arg_x));
      end
      pending_count <= expected_values.size();
   end

endmodule

[tb/tb.sv]
// Top of the polynomial evaluator testbench: clock, reset, coefficient setup
// and argument stimulus. Depends on poly_pkg, polynomial_evaluator, poly_checker.
`timescale 1ns / 1ps

module tb;
   import poly_pkg::*;

   localparam int MAX_DEG      = MAX_DEGREE_DEF;
   localparam int LATENCY      = 2 * MAX_DEG + 1;
   localparam int UNMAPPED_REG = NUM_COEF;
   localparam int CYCLE_LIMIT  = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_arg_x = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_result_y;
   logic              rsp_saturated;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   int                check_errors;
   int                pending_words;
   int                req_idle_pct = 0;
   int                rsp_idle_pct = 0;
   int                cycle_count = 0;
   logic [DATA_W-1:0] next_coefs [NUM_COEF];

   polynomial_evaluator #(.MAX_DEGREE(MAX_DEG)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_arg_x     (req_arg_x),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result_y  (rsp_result_y),
      .rsp_saturated (rsp_saturated),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   poly_checker #(.MAX_DEGREE(MAX_DEG)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_arg_x     (req_arg_x),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result_y  (rsp_result_y),
      .rsp_saturated (rsp_saturated),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .error_count   (check_errors),
      .pending_count (pending_words)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] random_fixed();
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(4))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               3: return DATA_W'(1);
               default: return '1;
            endcase
         end
         3: return $urandom_range(511) - 32'd256;
         4, 5: return $urandom_range(32'h1FFFFF) - 32'h100000;
         default: return $urandom_range(32'h3FFFF) - 32'h20000;
      endcase
   endfunction

   task automatic write_coef(input int index, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_coefs();
      for (int i = 0; i < NUM_COEF; i++) write_coef(i, next_coefs[i]);
   endtask

   task automatic send_arg(input logic [DATA_W-1:0] arg);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_arg_x <= arg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   initial begin
      logic [DATA_W-1:0] tie_args [8];
      tie_args = '{32'h00008000, 32'hFFFF8000, 32'h00010000, 32'hFFFF0000,
                   32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coefficients still at reset
      send_arg(Q_MAX);
      send_arg(Q_MIN);
      wait_idle();

      // all coefficients at the positive extreme; unmapped register must be ignored
      foreach (next_coefs[i]) next_coefs[i] = Q_MAX;
      program_coefs();
      write_coef(UNMAPPED_REG, 32'h12345678);
      send_arg(32'h00010000);
      send_arg(Q_MIN);
      send_arg('0);
      wait_idle();

      foreach (next_coefs[i]) next_coefs[i] = Q_MIN;
      program_coefs();
      send_arg(Q_MAX);
      send_arg('1);
      send_arg(DATA_W'(1));
      wait_idle();

      // small coefficients to hit rounding ties of both signs
      next_coefs = '{32'h00010000, 32'hFFFF8000, 32'h00000001, 32'hFFFFFFFF,
                     32'h00000000, 32'h00020000, 32'h00000001};
      program_coefs();
      foreach (tie_args[i]) send_arg(tie_args[i]);
      wait_idle();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct <= 34;
               rsp_idle_pct <= 64;
            end
            1: begin
               req_idle_pct <= 64;
               rsp_idle_pct <= 34;
            end
            default: begin
               req_idle_pct <= 0;
               rsp_idle_pct <= 0;
            end
         endcase
         for (int coef_set = 0; coef_set < 6; coef_set++) begin
            foreach (next_coefs[i]) next_coefs[i] = random_fixed();
            program_coefs();
            if ($urandom_range(1) == 1) write_coef(UNMAPPED_REG, $urandom);
            repeat (61) send_arg(random_fixed());
            wait_idle();
         end
      end

      wait_idle();
      repeat (4 * LATENCY) @(posedge clock);
      if (check_errors == 0 && pending_words == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
